@@ sv/circular_angle_calibration_unit_macros.svh @@
// assertion macros for the angle calibration unit
`ifndef CIRCULAR_ANGLE_CALIBRATION_UNIT_MACROS_SVH
`define CIRCULAR_ANGLE_CALIBRATION_UNIT_MACROS_SVH

// same-cycle implication
`define CACAL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cacal check failed");

// next-cycle implication
`define CACAL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cacal check failed");

`endif

@@ sv/cacal_pkg.sv @@
// shared types and constants for the angle calibration unit
`timescale 1ns / 1ps
package cacal_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int PROD_W     = 35;
  localparam int MAG_W      = 34;
  localparam int SCL_W      = 33;

  localparam logic [1:0] CMD_POINT = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CONV  = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

@@ sv/cacal_ram.sv @@
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module cacal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ sv/cacal_div.sv @@
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
module cacal_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [cacal_pkg::MAG_W-1:0] dividend,
  input  logic [15:0]              divisor,
  output logic [cacal_pkg::MAG_W-1:0] quotient,
  output cacal_pkg::div_stat_t     stat
);
  import cacal_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [15:0]      rem;
  logic [15:0]      dsr;
  logic [CNT_W-1:0] cnt;
  logic [16:0]      trial;

  assign trial = {rem, quotient[MAG_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(MAG_W);
        quotient  <= dividend;
        dsr       <= divisor;
        rem       <= '0;
      end else if (stat.busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem      <= 16'(trial - {1'b0, dsr});
          quotient <= {quotient[MAG_W-2:0], 1'b1};
        end else begin
          rem      <= trial[15:0];
          quotient <= {quotient[MAG_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ sv/circular_angle_calibration_unit.sv @@
// top level: per-sensor circular piecewise linear angle calibration
//
//  channel  dir  contents
//  s_*      in   tuser command; tdata sensor, slot, raw, true, count, zero, scale
//  m_*      out  tdata sensor, table angle, final angle
//
// one word at a time; point and settings words are handled without leaving idle
// a convert fetches points and tests segments in turn, then multiplies, divides and scales
// the divide is a restoring serial unit, one quotient bit per cycle
// synchronous reset clears counts, zero offsets and sets unity gain
// a finished result waits in the output register; input stalls only while busy
`timescale 1ns / 1ps
`include "circular_angle_calibration_unit_macros.svh"
module circular_angle_calibration_unit #(
  parameter int NUM_SENSORS = 4,
  parameter int MAX_POINTS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // sensor, point_index, raw_angle, physical_angle,
                                // point_count, zero_offset, scale, zero pad
  input  logic [1:0]  s_tuser,  // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // out_sensor, table_angle, final_angle, zero pad
);
  import cacal_pkg::*;

  localparam int DEPTH = NUM_SENSORS * MAX_POINTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FETCH = 4'd1;
  localparam logic [3:0] ST_LOAD  = 4'd2;
  localparam logic [3:0] ST_SEG   = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_DSTRT = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_SCALE = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  logic [1:0]  in_cmd, in_sensor;
  logic [3:0]  in_slot;
  logic [15:0] in_raw, in_phys, in_zero, in_scale;
  logic [4:0]  in_count;

  assign in_cmd    = s_tuser;
  assign in_sensor = s_tdata[1:0];
  assign in_slot   = s_tdata[5:2];
  assign in_raw    = s_tdata[21:6];
  assign in_phys   = s_tdata[37:22];
  assign in_count  = s_tdata[42:38];
  assign in_zero   = s_tdata[58:43];
  assign in_scale  = s_tdata[74:59];

  logic [CW-1:0]   cnt_tab  [NUM_SENSORS];
  logic [15:0]     zero_tab [NUM_SENSORS];
  logic [15:0]     gain_tab [NUM_SENSORS];

  logic [3:0]      state;
  logic [SW-1:0]   sen;
  logic [15:0]     raw;
  logic [CW-1:0]   n;
  logic [CW-1:0]   seg;
  logic            ld_first;
  logic [AW-1:0]   rd_addr;
  logic [15:0]     r0, p0, fr, fp, cr, cp;
  logic [15:0]     dd, dr;
  logic signed [17:0]       dp;
  logic signed [PROD_W-1:0] prod;
  logic            pneg;
  logic [15:0]     tbl;
  logic signed [SCL_W-1:0]  prod2;
  logic [15:0]     o_tbl, o_fin;
  logic [SW-1:0]   o_sen;

  logic            accept, in_ok;
  logic [SW-1:0]   in_sidx;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr;
  logic [31:0]     ram_rdata;

  logic [15:0]     seg_dr, seg_d, seg_diff;
  logic signed [17:0] seg_diffs, seg_dp;
  logic            seg_match;
  logic [CW:0]     seg_p1, seg_p2;
  logic [AW-1:0]   seg_addr;

  logic            div_start;
  logic [MAG_W-1:0] div_q;
  div_stat_t       div_stat;
  logic [MAG_W-1:0] qs;

  logic signed [16:0]      dz;
  logic signed [SCL_W-1:0] rnd;
  logic [15:0]             fin;
  logic                    out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_sidx  = SW'(in_sensor);
  assign in_ok    = (32'(in_sensor) < NUM_SENSORS);

  assign ram_we    = accept && in_ok && (in_cmd == CMD_POINT) && (32'(in_slot) < MAX_POINTS);
  assign ram_waddr = AW'(int'(in_sidx) * MAX_POINTS + int'(in_slot));
  assign ram_re    = (state == ST_FETCH);

  cacal_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_raw, in_phys}),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign div_start = (state == ST_DSTRT);

  cacal_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pneg ? MAG_W'(-prod) : MAG_W'(prod)),
    .divisor  (dr),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // segment test between point (r0,p0) and point (cr,cp)
  assign seg_dr    = cr - r0;
  assign seg_d     = raw - r0;
  assign seg_match = (seg_d <= seg_dr) || (n == CW'(2));
  assign seg_diff  = cp - p0 - seg_dr;
  assign seg_diffs = (seg_diff > 16'h8000) ? 18'sd0 + $signed({2'b0, seg_diff}) - 18'sd65536
                                           : $signed({2'b0, seg_diff});
  assign seg_dp    = $signed({2'b0, seg_dr}) + seg_diffs;
  assign seg_p1    = {1'b0, seg} + 1'b1;
  assign seg_p2    = {1'b0, seg} + 2'd2;
  assign seg_addr  = AW'(int'(sen) * MAX_POINTS + int'(seg_p2));

  assign qs   = pneg ? (~div_q + 1'b1) : div_q;
  assign dz   = $signed({1'b0, tbl}) - $signed({1'b0, zero_tab[sen]});
  assign rnd  = prod2 + (prod2[SCL_W-1] ? SCL_W'(4095) : SCL_W'(0));
  assign fin  = rnd[GAIN_FRAC+15:GAIN_FRAC];
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        cnt_tab[i]  <= '0;
        zero_tab[i] <= '0;
        gain_tab[i] <= 16'd4096;
      end
    end else begin
      if (m_tvalid && m_tready && !(state == ST_FIN && out_free)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && in_ok) begin
            if (in_cmd == CMD_SET) begin
              cnt_tab[in_sidx]  <= (32'(in_count) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                                : CW'(in_count);
              zero_tab[in_sidx] <= in_zero;
              gain_tab[in_sidx] <= in_scale;
            end else if (in_cmd == CMD_CONV) begin
              sen <= in_sidx;
              raw <= in_raw;
              n   <= cnt_tab[in_sidx];
              seg <= '0;
              if (cnt_tab[in_sidx] == '0) begin
                tbl   <= in_raw;
                state <= ST_SCALE;
              end else begin
                ld_first <= 1'b1;
                rd_addr  <= AW'(int'(in_sidx) * MAX_POINTS);
                state    <= ST_FETCH;
              end
            end
          end
        end
        ST_FETCH: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (ld_first) begin
            ld_first <= 1'b0;
            fr <= ram_rdata[31:16];
            fp <= ram_rdata[15:0];
            r0 <= ram_rdata[31:16];
            p0 <= ram_rdata[15:0];
            if (n == CW'(1)) begin
              tbl   <= raw - ram_rdata[31:16] + ram_rdata[15:0];
              state <= ST_SCALE;
            end else begin
              rd_addr <= AW'(int'(sen) * MAX_POINTS + 1);
              state   <= ST_FETCH;
            end
          end else begin
            cr    <= ram_rdata[31:16];
            cp    <= ram_rdata[15:0];
            state <= ST_SEG;
          end
        end
        ST_SEG: begin
          if (seg_match) begin
            if (seg_dr == '0) begin
              tbl   <= p0;
              state <= ST_SCALE;
            end else begin
              dd    <= seg_d;
              dr    <= seg_dr;
              dp    <= seg_dp;
              state <= ST_MUL;
            end
          end else begin
            r0 <= cr;
            p0 <= cp;
            if (seg_p1 >= {1'b0, n}) begin
              tbl   <= raw;
              state <= ST_SCALE;
            end else begin
              seg <= seg_p1[CW-1:0];
              if (seg_p2 == {1'b0, n}) begin
                cr <= fr;
                cp <= fp;
              end else begin
                rd_addr <= seg_addr;
                state   <= ST_FETCH;
              end
            end
          end
        end
        ST_MUL: begin
          prod  <= PROD_W'($signed({2'b0, dd}) * dp);
          pneg  <= dp[17];
          state <= ST_DSTRT;
        end
        ST_DSTRT: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            tbl   <= p0 + qs[15:0];
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          prod2 <= SCL_W'(dz * $signed(gain_tab[sen]));
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            o_sen    <= sen;
            o_tbl    <= tbl;
            o_fin    <= fin;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {6'b0, o_fin, o_tbl, 2'(o_sen)};

  `CACAL_ASSERT_IMP(a_div_in_state, div_stat.busy, (state == ST_DIV))
  `CACAL_ASSERT_IMP(a_ram_no_clash, ram_re, !ram_we)
  `CACAL_ASSERT_IMP(a_seg_in_range, (state == ST_SEG), (seg < n))
  `CACAL_ASSERT_IMP(a_result_src, $rose(m_tvalid), ($past(state) == ST_FIN))
endmodule
